// File: hdl/pee_pkg.sv
package pee_pkg;

  // Default sizes
  localparam int DEF_BUFFER_LENGTH = 64;
  localparam int DEF_STACK_DEPTH   = 32;

  localparam int WORD_W    = 32;
  localparam int CHAR_W    = 8;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 6;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_DIG0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG9  = 8'h39;

  // One accepted input beat
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] code;
    logic              last;
  } ld_beat_t;

  // Finished result
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              div0;
    logic              full;
    logic              trunc;
  } res_t;

  // Divider request / response
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: hdl/pee_div.sv
module pee_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pee_pkg::div_req_t  req,
  output pee_pkg::div_rsp_t  rsp
);

  logic                            busy_r, busy_nxt;
  logic [pee_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pee_pkg::WORD_W-1:0]      q_r, q_nxt;
  logic [pee_pkg::WORD_W-1:0]      r_r, r_nxt;
  logic [pee_pkg::WORD_W-1:0]      dvs_r, dvs_nxt;
  logic                            negq_r, negq_nxt;
  logic                            negr_r, negr_nxt;
  logic [pee_pkg::WORD_W:0]        shifted;
  logic [pee_pkg::WORD_W:0]        diff;
  logic [pee_pkg::WORD_W-1:0]      a_mag;
  logic [pee_pkg::WORD_W-1:0]      b_mag;

  // Magnitudes of the signed operands
  assign a_mag = req.dividend[pee_pkg::WORD_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign b_mag = req.divisor[pee_pkg::WORD_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;

  // One restoring step per cycle
  assign shifted = {r_r, q_r[pee_pkg::WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    dvs_nxt  = dvs_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = pee_pkg::DIV_CNT_W'(pee_pkg::DIV_STEPS);
      q_nxt    = a_mag;
      r_nxt    = '0;
      dvs_nxt  = b_mag;
      negq_nxt = req.dividend[pee_pkg::WORD_W-1] ^ req.divisor[pee_pkg::WORD_W-1];
      negr_nxt = req.dividend[pee_pkg::WORD_W-1];
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (!diff[pee_pkg::WORD_W]) begin
          r_nxt = diff[pee_pkg::WORD_W-1:0];
          q_nxt = {q_r[pee_pkg::WORD_W-2:0], 1'b1};
        end else begin
          r_nxt = shifted[pee_pkg::WORD_W-1:0];
          q_nxt = {q_r[pee_pkg::WORD_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    dvs_r  <= dvs_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  // Sign fix on the way out; valid in the done cycle
  assign rsp.done      = busy_r && (cnt_r == '0);
  assign rsp.quotient  = negq_r ? (~q_r + 1'b1) : q_r;
  assign rsp.remainder = negr_r ? (~r_r + 1'b1) : r_r;

endmodule

// File: hdl/pee_core.sv
module pee_core #(
  parameter int BUFFER_LENGTH = pee_pkg::DEF_BUFFER_LENGTH,
  parameter int STACK_DEPTH   = pee_pkg::DEF_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pee_pkg::ld_beat_t  ld,
  output logic               ld_ready,
  output logic               res_valid,
  output pee_pkg::res_t      res,
  input  logic               res_take
);

  localparam int BAW  = $clog2(BUFFER_LENGTH);
  localparam int CW   = BAW + 1;
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SPW  = SAW + 1;
  localparam int W    = pee_pkg::WORD_W;
  localparam logic [CW-1:0]  BL_C = CW'(BUFFER_LENGTH);
  localparam logic [SPW-1:0] SD_C = SPW'(STACK_DEPTH);

  typedef enum logic [10:0] {
    S_LOAD = 11'b00000000001,
    S_RD   = 11'b00000000010,
    S_CHR  = 11'b00000000100,
    S_POPA = 11'b00000001000,
    S_POPB = 11'b00000010000,
    S_OP   = 11'b00000100000,
    S_DIV  = 11'b00001000000,
    S_PUSH = 11'b00010000000,
    S_FIN  = 11'b00100000000,
    S_TOP  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [SPW-1:0]            sp_r, sp_nxt;
  logic                      ended_r, ended_nxt;
  logic                      pend_r, pend_nxt;
  logic                      div0_r, div0_nxt;
  logic                      full_r, full_nxt;
  logic                      trunc_r, trunc_nxt;
  logic                      avld_r, avld_nxt;
  logic                      bvld_r, bvld_nxt;
  logic [W-1:0]              acc_r, acc_nxt;
  logic [W-1:0]              place_r, place_nxt;
  logic [W-1:0]              a_r, a_nxt;
  logic [W-1:0]              res_r, res_nxt;

  // Buffer memory
  logic [pee_pkg::CHAR_W-1:0] buf_mem [BUFFER_LENGTH];
  logic                       buf_we;
  logic [BAW-1:0]             buf_wa;
  logic                       buf_re;
  logic [BAW-1:0]             buf_ra;
  logic [pee_pkg::CHAR_W-1:0] buf_q;

  // Stack memory
  logic [W-1:0]               stk_mem [STACK_DEPTH];
  logic                       stk_we;
  logic [SAW-1:0]             stk_wa;
  logic [W-1:0]               stk_wd;
  logic                       stk_re;
  logic [SAW-1:0]             stk_ra;
  logic [W-1:0]               stk_q;

  logic                       push_en;
  logic [W-1:0]               push_val;
  logic [CW-1:0]              idx_m1;
  logic [SPW-1:0]             sp_m1;
  logic                       is_digit;
  logic                       is_op;
  logic                       is_divop;
  logic [W+3:0]               dig_prod;
  logic [W-1:0]               b_val;

  pee_pkg::div_req_t          div_req;
  pee_pkg::div_rsp_t          div_rsp;

  pee_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Handshakes follow the state only
  assign ld_ready  = (state_r == S_LOAD);
  assign res_valid = (state_r == S_OUT);

  // Character decode on the registered buffer read
  assign is_digit = (buf_q >= pee_pkg::CH_DIG0) && (buf_q <= pee_pkg::CH_DIG9);
  assign is_divop = (buf_q == pee_pkg::CH_SLASH) || (buf_q == pee_pkg::CH_PCT);
  assign is_op    = (buf_q == pee_pkg::CH_PLUS) || (buf_q == pee_pkg::CH_MINUS) ||
                    (buf_q == pee_pkg::CH_STAR) || is_divop;
  assign dig_prod = place_r * buf_q[3:0];
  assign idx_m1   = idx_r - 1'b1;
  assign sp_m1    = sp_r - 1'b1;
  assign b_val    = bvld_r ? stk_q : '0;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sp_nxt    = sp_r;
    ended_nxt = ended_r;
    pend_nxt  = pend_r;
    div0_nxt  = div0_r;
    full_nxt  = full_r;
    trunc_nxt = trunc_r;
    avld_nxt  = avld_r;
    bvld_nxt  = bvld_r;
    acc_nxt   = acc_r;
    place_nxt = place_r;
    a_nxt     = a_r;
    res_nxt   = res_r;
    buf_we    = 1'b0;
    buf_wa    = cnt_r[BAW-1:0];
    buf_re    = 1'b0;
    buf_ra    = idx_m1[BAW-1:0];
    stk_re    = 1'b0;
    stk_ra    = sp_m1[SAW-1:0];
    push_en   = 1'b0;
    push_val  = acc_r;
    div_req.start    = 1'b0;
    div_req.dividend = a_r;
    div_req.divisor  = b_val;

    unique case (state_r)
      S_LOAD: begin
        if (ld.valid) begin
          if (!ended_r) begin
            if (ld.code == pee_pkg::CH_NUL) begin
              ended_nxt = 1'b1;
            end else if (cnt_r < BL_C) begin
              buf_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              trunc_nxt = 1'b1;
            end
          end
          if (ld.last) begin
            idx_nxt   = cnt_nxt;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          buf_re    = 1'b1;
          idx_nxt   = idx_m1;
          state_nxt = S_CHR;
        end
      end
      S_CHR: begin
        if (is_digit) begin
          acc_nxt   = acc_r + dig_prod[W-1:0];
          place_nxt = (place_r << 3) + (place_r << 1);
          pend_nxt  = 1'b1;
          state_nxt = S_RD;
        end else begin
          if (pend_r) begin
            push_en   = 1'b1;
            acc_nxt   = '0;
            place_nxt = W'(1);
            pend_nxt  = 1'b0;
          end
          state_nxt = is_op ? S_POPA : S_RD;
        end
      end
      S_POPA: begin
        avld_nxt = (sp_r != '0);
        if (sp_r != '0) begin
          stk_re = 1'b1;
          sp_nxt = sp_m1;
        end
        state_nxt = S_POPB;
      end
      S_POPB: begin
        a_nxt    = avld_r ? stk_q : '0;
        bvld_nxt = (sp_r != '0);
        if (sp_r != '0) begin
          stk_re = 1'b1;
          sp_nxt = sp_m1;
        end
        state_nxt = S_OP;
      end
      S_OP: begin
        state_nxt = S_PUSH;
        priority if (buf_q == pee_pkg::CH_PLUS) begin
          res_nxt = a_r + b_val;
        end else if (buf_q == pee_pkg::CH_MINUS) begin
          res_nxt = a_r - b_val;
        end else if (buf_q == pee_pkg::CH_STAR) begin
          res_nxt = a_r * b_val;
        end else if (b_val == '0) begin
          div0_nxt = 1'b1;
          res_nxt  = '0;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = (buf_q == pee_pkg::CH_SLASH) ? div_rsp.quotient : div_rsp.remainder;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        push_en   = 1'b1;
        push_val  = res_r;
        state_nxt = S_RD;
      end
      S_FIN: begin
        if (pend_r) begin
          push_en   = 1'b1;
          acc_nxt   = '0;
          place_nxt = W'(1);
          pend_nxt  = 1'b0;
        end
        state_nxt = S_TOP;
      end
      S_TOP: begin
        if (sp_r != '0) begin
          stk_re = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_take) begin
          cnt_nxt   = '0;
          idx_nxt   = '0;
          sp_nxt    = '0;
          ended_nxt = 1'b0;
          pend_nxt  = 1'b0;
          div0_nxt  = 1'b0;
          full_nxt  = 1'b0;
          trunc_nxt = 1'b0;
          acc_nxt   = '0;
          place_nxt = W'(1);
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // Shared push with overflow drop
    stk_we = 1'b0;
    stk_wa = sp_r[SAW-1:0];
    stk_wd = push_val;
    if (push_en) begin
      if (sp_r >= SD_C) begin
        full_nxt = 1'b1;
      end else begin
        stk_we = 1'b1;
        sp_nxt = sp_r + 1'b1;
      end
    end
  end

  // Result bundle
  assign res.value = (sp_r != '0) ? stk_q : '0;
  assign res.div0  = div0_r;
  assign res.full  = full_r;
  assign res.trunc = trunc_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
      sp_r    <= '0;
      ended_r <= 1'b0;
      pend_r  <= 1'b0;
      div0_r  <= 1'b0;
      full_r  <= 1'b0;
      trunc_r <= 1'b0;
      avld_r  <= 1'b0;
      bvld_r  <= 1'b0;
      acc_r   <= '0;
      place_r <= W'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      sp_r    <= sp_nxt;
      ended_r <= ended_nxt;
      pend_r  <= pend_nxt;
      div0_r  <= div0_nxt;
      full_r  <= full_nxt;
      trunc_r <= trunc_nxt;
      avld_r  <= avld_nxt;
      bvld_r  <= bvld_nxt;
      acc_r   <= acc_nxt;
      place_r <= place_nxt;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    res_r <= res_nxt;
  end

  // Expression buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_wa] <= ld.code;
    end
    if (buf_re) begin
      buf_q <= buf_mem[buf_ra];
    end
  end

  // Operand stack: one write, one registered read
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  // Checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SD_C)
    else $error("stack pointer beyond depth");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= BL_C)
    else $error("byte count beyond buffer");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with zero divisor");

  a_clear_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take) |=> (cnt_r == '0) && (sp_r == '0) && !ended_r)
    else $error("state not cleared after result");

  a_push_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_en && (sp_r >= SD_C)) |=> full_r)
    else $error("dropped push not flagged");

endmodule

// File: hdl/prefix_expression_evaluator_top.sv
// Prefix expression evaluator.
// Input stream: one ASCII byte per beat on in_tdata, in_tlast on the final
// byte. Bytes are stored in an expression buffer at one beat per cycle; a zero
// byte ends the expression and later bytes up to the tlast beat are ignored.
// The tlast beat starts evaluation: the buffer is walked from its end with an
// operand stack held in a synchronous memory. in_tready is low while this runs.
// Evaluation takes each stored byte through a read state and a decode state;
// an operator then pops two operands, computes and pushes the result, and / or
// % with a nonzero divisor also waits for the 32-step iterative divider. A
// number is pushed when the walk reaches the non-digit byte that ends it. After
// the walk a pending number is pushed and the stack top is read as the result.
// Output stream: one beat per expression, value on out_tdata and the three
// error flags on out_tuser. The result sits in an output register; a stalled
// receiver does not block loading of the next expression, only the end of its
// evaluation, which waits until the register is free.
// Reset: synchronous, active low; the block comes up empty and ready for
// bytes. Buffer and stack memories need no clearing.
module prefix_expression_evaluator_top #(
  parameter int BUFFER_LENGTH = pee_pkg::DEF_BUFFER_LENGTH,
  parameter int STACK_DEPTH   = pee_pkg::DEF_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [2:0]  out_tuser   // [0] divide_by_zero, [1] stack_full, [2] truncated
);

  pee_pkg::ld_beat_t ld;
  pee_pkg::res_t     res;
  logic              ld_ready;
  logic              res_valid;
  logic              res_take;
  logic              out_tvalid_r;
  logic [31:0]       out_tdata_r;
  logic [2:0]        out_tuser_r;

  // Input beat; the core only looks at it while ready
  assign in_tready = ld_ready;
  assign ld.valid  = in_tvalid;
  assign ld.code   = in_tdata;
  assign ld.last   = in_tlast;

  // Output register takes a result when empty or being drained
  assign res_take = res_valid && (!out_tvalid_r || out_tready);

  pee_core #(
    .BUFFER_LENGTH (BUFFER_LENGTH),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .ld_ready  (ld_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_tdata_r <= res.value;
      out_tuser_r <= {res.trunc, res.full, res.div0};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: test/expression_checker.sv
`timescale 1ns / 100ps

module expression_checker #(
  parameter int BUFFER_LENGTH = pee_pkg::DEF_BUFFER_LENGTH,
  parameter int STACK_DEPTH   = pee_pkg::DEF_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] value
  input  logic [2:0]  out_tuser,  // [0] divide_by_zero, [1] stack_full, [2] truncated
  output int          mismatches,
  output int          awaiting
);

  // Shadow of the expression being loaded
  logic [7:0]  expr_mem [BUFFER_LENGTH];
  int          stored   = 0;
  bit          nul_seen = 1'b0;
  bit          dropped  = 1'b0;

  // Operand stack used while working out a result
  logic [31:0] operands [STACK_DEPTH];
  int          depth    = 0;
  bit          saw_div0 = 1'b0;
  bit          saw_full = 1'b0;

  pee_pkg::res_t pending_results [$];
  int            err_count = 0;

  function automatic bit is_operator(logic [7:0] c);
    return c == pee_pkg::CH_PLUS || c == pee_pkg::CH_MINUS || c == pee_pkg::CH_STAR ||
           c == pee_pkg::CH_SLASH || c == pee_pkg::CH_PCT;
  endfunction

  // A push onto a full stack is lost and flagged
  function void push_operand(logic [31:0] v);
    if (depth >= STACK_DEPTH) begin
      saw_full = 1'b1;
    end else begin
      operands[depth] = v;
      depth++;
    end
  endfunction

  // An empty stack gives zero
  function logic [31:0] pop_operand();
    if (depth == 0) return '0;
    depth--;
    return operands[depth];
  endfunction

  // a op b; divide and remainder truncate toward zero, zero divisor gives zero
  function logic [31:0] combine(logic [7:0] op, logic [31:0] a, logic [31:0] b);
    longint sa, sb;
    if (op == pee_pkg::CH_PLUS) return a + b;
    if (op == pee_pkg::CH_MINUS) return a - b;
    if (op == pee_pkg::CH_STAR) return a * b;
    if (b == '0) begin
      saw_div0 = 1'b1;
      return '0;
    end
    // 64-bit math keeps most-negative / -1 from overflowing
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    sa = (op == pee_pkg::CH_SLASH) ? sa / sb : sa % sb;
    return sa[31:0];
  endfunction

  // Walk the stored bytes from the end, digit runs weighted by place value
  function pee_pkg::res_t evaluate_expr();
    logic [31:0]   acc, place, a, b;
    logic [7:0]    c;
    bit            in_number;
    pee_pkg::res_t r;
    depth     = 0;
    saw_div0  = 1'b0;
    saw_full  = 1'b0;
    acc       = '0;
    place     = 32'd1;
    in_number = 1'b0;
    for (int i = stored - 1; i >= 0; i--) begin
      c = expr_mem[i];
      if (c >= pee_pkg::CH_DIG0 && c <= pee_pkg::CH_DIG9) begin
        acc       = acc + 32'(c - pee_pkg::CH_DIG0) * place;
        place     = place * 32'd10;
        in_number = 1'b1;
      end else begin
        if (in_number) begin
          push_operand(acc);
          acc       = '0;
          place     = 32'd1;
          in_number = 1'b0;
        end
        if (is_operator(c)) begin
          a = pop_operand();
          b = pop_operand();
          push_operand(combine(c, a, b));
        end
      end
    end
    if (in_number) push_operand(acc);
    r.value = (depth > 0) ? operands[depth - 1] : '0;
    r.div0  = saw_div0;
    r.full  = saw_full;
    r.trunc = dropped;
    return r;
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      err_count++;
    end
  endfunction

  // Watch both channels at every edge
  always @(posedge clk) begin
    pee_pkg::res_t want;
    if (!rst_n) begin
      stored          = 0;
      nul_seen        = 1'b0;
      dropped         = 1'b0;
      pending_results = {};
      err_count       = 0;
    end else begin
      // load beat
      if (in_tvalid && in_tready) begin
        if (!nul_seen) begin
          if (in_tdata == pee_pkg::CH_NUL) begin
            nul_seen = 1'b1;
          end else if (stored < BUFFER_LENGTH) begin
            expr_mem[stored] = in_tdata;
            stored++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (in_tlast) begin
          pending_results.push_back(evaluate_expr());
          stored   = 0;
          nul_seen = 1'b0;
          dropped  = 1'b0;
        end
      end
      // result beat
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h / %b", $time,
                   out_tdata, out_tuser);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("value", want.value, out_tdata);
          compare_field("divide_by_zero", want.div0, out_tuser[0]);
          compare_field("stack_full", want.full, out_tuser[1]);
          compare_field("truncated", want.trunc, out_tuser[2]);
        end
      end
    end
    mismatches <= err_count;
    awaiting   <= pending_results.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         ITEM_TARGET = 1950;
  localparam logic [7:0] SEP_SPACE   = 8'h20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  int          mismatches;
  int          awaiting;
  int          cycle      = 0;
  int          items_sent = 0;
  int          stall_left = 0;
  logic [7:0]  expr_bytes [$];

  always #4 clk = ~clk;

  prefix_expression_evaluator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  expression_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random back-pressure, two long holds, one calm stretch
  always @(posedge clk) begin
    if (cycle == 1500 || cycle == 3000) stall_left = 400;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (cycle >= 4000 && cycle < 6500) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 19);
    end
  end

  // One byte beat, with random gaps outside the quiet window
  task automatic send_beat(input logic [7:0] code, input logic fin);
    if (items_sent < 900 || items_sent >= 1250) begin
      while ($urandom_range(0, 99) < 19) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and hold until every result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // Send the queued bytes, tlast on the final one
  task automatic emit_expression();
    foreach (expr_bytes[k]) begin
      send_beat(expr_bytes[k], k == expr_bytes.size() - 1);
      items_sent++;
    end
    expr_bytes = {};
  endtask

  task automatic put_text(input string s);
    for (int k = 0; k < s.len(); k++) expr_bytes.push_back(s[k]);
  endtask

  task automatic append_decimal(input logic [63:0] v);
    logic [7:0] digs [$];
    digs = {};
    do begin
      digs.push_front(pee_pkg::CH_DIG0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[k]) expr_bytes.push_back(digs[k]);
  endtask

  // Mostly small numbers; zeros for divisors, full words, wrap cases, long runs
  task automatic append_number();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      append_decimal(64'd0);
    end else if (pick < 65) begin
      append_decimal(64'($urandom_range(1, 99)));
    end else if (pick < 85) begin
      append_decimal(64'($urandom));
    end else if (pick < 93) begin
      // most negative word and minus one, directly and through wrap
      case ($urandom_range(0, 2))
        0:       append_decimal(64'd2147483648);
        1:       append_decimal(64'd4294967295);
        default: append_decimal(64'd6442450944);
      endcase
    end else begin
      repeat ($urandom_range(11, 20)) begin
        expr_bytes.push_back(pee_pkg::CH_DIG0 + 8'($urandom_range(0, 9)));
      end
    end
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return pee_pkg::CH_PLUS;
      1:       return pee_pkg::CH_MINUS;
      2:       return pee_pkg::CH_STAR;
      3:       return pee_pkg::CH_SLASH;
      default: return pee_pkg::CH_PCT;
    endcase
  endfunction

  // Separator: usually a space, else any byte that is no digit or operator
  function automatic logic [7:0] pick_gap();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 9) < 7 || (c >= pee_pkg::CH_DIG0 && c <= pee_pkg::CH_DIG9) ||
        c == pee_pkg::CH_PLUS || c == pee_pkg::CH_MINUS || c == pee_pkg::CH_STAR ||
        c == pee_pkg::CH_SLASH || c == pee_pkg::CH_PCT) begin
      c = SEP_SPACE;
    end
    return c;
  endfunction

  // Well-formed prefix formula: track operand slots still to fill
  task automatic build_formula(input int max_ops);
    int open_slots, ops_left;
    open_slots = 1;
    ops_left   = $urandom_range(0, max_ops);
    while (open_slots > 0) begin
      if (ops_left > 0 && $urandom_range(0, 2) != 0) begin
        expr_bytes.push_back(pick_op());
        ops_left--;
        open_slots++;
        if ($urandom_range(0, 1)) expr_bytes.push_back(pick_gap());
      end else begin
        append_number();
        open_slots--;
        if (open_slots > 0) expr_bytes.push_back(pick_gap());
      end
    end
  endtask

  initial begin
    int kind, n, target;
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // all operators, 0xFF as separator, zero divisor, pop from empty stack,
    // then an end byte followed by an ignored byte
    put_text("+*-/%7");
    expr_bytes.push_back(8'hFF);
    put_text("0 5 3 2");
    expr_bytes.push_back(pee_pkg::CH_NUL);
    expr_bytes.push_back(8'h51);
    emit_expression();
    // wrapped digit run to the most negative word, divided by minus one
    put_text("/6442450944-0 1");
    emit_expression();
    // empty expression
    expr_bytes.push_back(pee_pkg::CH_NUL);
    emit_expression();

    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= 1000) begin
        paused = 1'b1;
        wait_drained();
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        build_formula(($urandom_range(0, 9) == 0) ? 14 : 5);
      end else if (kind < 63) begin
        // operand count off: extra operators in front or a stray number behind
        build_formula(4);
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 3)) expr_bytes.push_front(pick_op());
        end else begin
          expr_bytes.push_back(SEP_SPACE);
          append_number();
        end
      end else if (kind < 70) begin
        // one operator on an empty stack plus a run of numbers that can fill the stack
        n = $urandom_range(30, 34);
        for (int k = 0; k < n; k++) begin
          expr_bytes.push_back(pee_pkg::CH_DIG0 + 8'($urandom_range(1, 9)));
          if (k < n - 1) expr_bytes.push_back(SEP_SPACE);
        end
        expr_bytes.push_back(pick_op());
      end else if (kind < 78) begin
        // longer than the buffer
        build_formula(8);
        target = $urandom_range(65, 100);
        while (expr_bytes.size() < target) expr_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 88) begin
        build_formula(5);
        expr_bytes.push_back(pee_pkg::CH_NUL);
        repeat ($urandom_range(0, 5)) expr_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) expr_bytes.push_back(8'($urandom_range(0, 255)));
      end
      emit_expression();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pee_pkg.sv
hdl/pee_div.sv
hdl/pee_core.sv
hdl/prefix_expression_evaluator_top.sv
test/expression_checker.sv
test/testbench.sv
